FILE: design/wcp_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// wcp_pkg
// Shared types and constants for the wave chunk header parser.
// ---------------------------------------------------------------------------
package wcp_pkg;

    // chunk ids, little-endian as assembled from the byte stream
    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_FMT  = 32'h2074_6d66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_BODY_BYTES = 32'd16;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_UNSUP   = 2'd1;
    localparam logic [1:0] ST_CORRUPT = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_DEPTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS  = 2'd1;

    localparam logic [15:0] RST_BIT_DEPTH = 16'd16;
    localparam logic [15:0] RST_CHANNELS  = 16'd2;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0]  file_byte;
        logic        last_byte;
        logic [31:0] pos;
    } wcp_entry_t;

    typedef struct packed {
        logic                 wen;
        logic [CFG_IDX_W-1:0] index;
        logic [15:0]          data;
    } wcp_cfg_wr_t;

endpackage : wcp_pkg
`default_nettype wire

FILE: design/wav_chunk_header_parser_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// wav_chunk_header_parser_top
// Walks the chunks of a wave file one byte per beat and reports the data
// chunk's size, offset and the fmt fields, or a corrupt status.
// ---------------------------------------------------------------------------
// Usage: feed the file one byte per input beat, marking the final byte with
// s_last_byte. The block takes one byte per cycle; the input and output
// sides are decoupled by a four-entry queue and a result register. While a
// result waits to be taken the parser holds, so up to four more bytes are
// taken before s_ready drops; the sustained rate is one beat per cycle as
// long as results are taken promptly. With an empty queue an input beat is
// written into the queue first, then the parser's field step for it can
// write the result register that drives the result beat.
// Each file gives exactly one result beat: status OK or UNSUPPORTED when the
// data chunk header completes, or CORRUPT on the last byte if no data chunk
// was found. Bytes after a result are dropped until the last byte, and the
// parser restarts after every last byte. Configuration (required bit depth
// at index 0, required channels at index 1) is taken in any cycle
// (cfg_ready is always high) and should be written while the block is idle.
// ---------------------------------------------------------------------------
module wav_chunk_header_parser_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // byte input
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [7:0]                    s_file_byte,
    input  wire logic                          s_last_byte,
    // result output
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [1:0]                         m_status,
    output logic [15:0]                        m_audio_format,
    output logic [15:0]                        m_channel_count,
    output logic [31:0]                        m_sample_rate,
    output logic [31:0]                        m_byte_rate,
    output logic [15:0]                        m_block_align,
    output logic [15:0]                        m_bit_depth,
    output logic [31:0]                        m_data_size,
    output logic [31:0]                        m_data_offset,
    // configuration writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [wcp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                   cfg_data
);
    import wcp_pkg::*;

    logic        push;
    wcp_entry_t  push_entry;
    logic        q_full;
    logic        q_pop;
    logic        q_not_empty;
    wcp_entry_t  q_head;
    wcp_cfg_wr_t cfg_wr;

    // register writes never stall
    assign cfg_ready    = 1'b1;
    assign cfg_wr.wen   = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    // front: accept beats, tag with file position
    wcp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_file_byte(s_file_byte),
        .s_last_byte(s_last_byte),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    // decoupling queue
    wcp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_entry(push_entry),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // back: chunk walker and result register
    wcp_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr         (cfg_wr),
        .q_not_empty    (q_not_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_audio_format (m_audio_format),
        .m_channel_count(m_channel_count),
        .m_sample_rate  (m_sample_rate),
        .m_byte_rate    (m_byte_rate),
        .m_block_align  (m_block_align),
        .m_bit_depth    (m_bit_depth),
        .m_data_size    (m_data_size),
        .m_data_offset  (m_data_offset)
    );

endmodule : wav_chunk_header_parser_top
`default_nettype wire

FILE: design/wcp_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// wcp_front
// Accepts file bytes and tags each with its file position.
// ---------------------------------------------------------------------------
module wcp_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_file_byte,
    input  wire logic               s_last_byte,
    output logic                    push,
    output wcp_pkg::wcp_entry_t     push_entry,
    input  wire logic               q_full
);
    import wcp_pkg::*;

    logic [31:0] pos_reg;
    logic [31:0] pos_next;

    assign s_ready = ~q_full;
    assign push    = s_valid & ~q_full;

    assign push_entry.file_byte = s_file_byte;
    assign push_entry.last_byte = s_last_byte;
    assign push_entry.pos       = pos_reg;

    // position restarts after the byte marked last
    always_comb begin
        pos_next = pos_reg;
        if (push) begin
            pos_next = s_last_byte ? 32'd0 : pos_reg + 32'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule : wcp_front
`default_nettype wire

FILE: design/wcp_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// wcp_queue
// Short FIFO of tagged bytes between front and back.
// ---------------------------------------------------------------------------
module wcp_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire wcp_pkg::wcp_entry_t push_entry,
    output logic                    full,
    input  wire logic               pop,
    output logic                    not_empty,
    output wcp_pkg::wcp_entry_t     head
);
    import wcp_pkg::*;

    wcp_entry_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]         count_reg, count_next;

    assign full      = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule : wcp_queue
`default_nettype wire

FILE: design/wcp_parser.sv
`default_nettype none
// ---------------------------------------------------------------------------
// wcp_parser
// Chunk walker: assembles fields, skips chunks, drives the result register.
// ---------------------------------------------------------------------------
module wcp_parser (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire wcp_pkg::wcp_cfg_wr_t cfg_wr,
    input  wire logic                q_not_empty,
    input  wire wcp_pkg::wcp_entry_t q_head,
    output logic                     q_pop,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [1:0]               m_status,
    output logic [15:0]              m_audio_format,
    output logic [15:0]              m_channel_count,
    output logic [31:0]              m_sample_rate,
    output logic [31:0]              m_byte_rate,
    output logic [15:0]              m_block_align,
    output logic [15:0]              m_bit_depth,
    output logic [31:0]              m_data_size,
    output logic [31:0]              m_data_offset
);
    import wcp_pkg::*;

    typedef enum logic [9:0] {
        PH_ID     = 10'b00_0000_0001,
        PH_FORM   = 10'b00_0000_0010,
        PH_FMT_AF = 10'b00_0000_0100,
        PH_FMT_CH = 10'b00_0000_1000,
        PH_FMT_SR = 10'b00_0001_0000,
        PH_FMT_BR = 10'b00_0010_0000,
        PH_FMT_BA = 10'b00_0100_0000,
        PH_FMT_BD = 10'b00_1000_0000,
        PH_SKIP   = 10'b01_0000_0000,
        PH_DONE   = 10'b10_0000_0000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  idx_reg, idx_next;
    logic [31:0] word_reg, word_next;
    logic [31:0] chunk_id_reg, chunk_id_next;
    logic [31:0] skip_reg, skip_next;
    logic [15:0] af_reg, af_next;
    logic [15:0] ch_reg, ch_next;
    logic [31:0] sr_reg, sr_next;
    logic [31:0] br_reg, br_next;
    logic [15:0] ba_reg, ba_next;
    logic [15:0] bd_reg, bd_next;
    logic [15:0] req_bd_reg, req_ch_reg;

    logic        m_valid_reg;
    logic [1:0]  st_reg;
    logic [15:0] o_af_reg, o_ch_reg, o_ba_reg, o_bd_reg;
    logic [31:0] o_sr_reg, o_br_reg, o_size_reg, o_off_reg;

    logic        emit;
    logic [1:0]  emit_st;
    logic [31:0] emit_size, emit_off;
    logic [15:0] emit_af, emit_ch, emit_ba, emit_bd;
    logic [31:0] emit_sr, emit_br;
    logic [31:0] word_ins;
    logic [2:0]  len_m1;
    logic        short_field;

    // a byte leaves the queue only when the result register can take a result
    assign q_pop = q_not_empty & (~m_valid_reg | m_ready);

    assign word_ins = word_reg |
        ({24'd0, q_head.file_byte} << {idx_reg[1:0], 3'b000});

    assign short_field = (phase_reg == PH_FMT_AF) || (phase_reg == PH_FMT_CH) ||
                         (phase_reg == PH_FMT_BA) || (phase_reg == PH_FMT_BD);
    assign len_m1 = short_field ? 3'd1 : 3'd3;

    always_comb begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        word_next     = word_reg;
        chunk_id_next = chunk_id_reg;
        skip_next     = skip_reg;
        af_next       = af_reg;
        ch_next       = ch_reg;
        sr_next       = sr_reg;
        br_next       = br_reg;
        ba_next       = ba_reg;
        bd_next       = bd_reg;
        emit          = 1'b0;
        emit_st       = ST_OK;
        emit_size     = '0;
        emit_off      = '0;
        emit_af       = '0;
        emit_ch       = '0;
        emit_sr       = '0;
        emit_br       = '0;
        emit_ba       = '0;
        emit_bd       = '0;

        if (q_pop) begin
            unique case (phase_reg)
                PH_ID: begin
                    if (idx_reg == 3'd3) begin
                        chunk_id_next = word_ins;
                        word_next     = '0;
                        idx_next      = 3'd4;
                    end else if (idx_reg == 3'd7) begin
                        word_next = '0;
                        idx_next  = '0;
                        if (chunk_id_reg == ID_RIFF) begin
                            phase_next = PH_FORM;
                        end else if (chunk_id_reg == ID_FMT) begin
                            skip_next  = (word_ins > FMT_BODY_BYTES) ?
                                         word_ins - FMT_BODY_BYTES : 32'd0;
                            phase_next = PH_FMT_AF;
                        end else if (chunk_id_reg == ID_DATA) begin
                            emit       = 1'b1;
                            emit_st    = (bd_reg != req_bd_reg || ch_reg != req_ch_reg) ?
                                         ST_UNSUP : ST_OK;
                            emit_size  = word_ins;
                            emit_off   = q_head.pos + 32'd1;
                            phase_next = PH_DONE;
                        end else begin
                            skip_next  = word_ins;
                            phase_next = (word_ins != '0) ? PH_SKIP : PH_ID;
                        end
                    end else begin
                        word_next = word_ins;
                        idx_next  = idx_reg + 3'd1;
                    end
                end
                PH_FORM, PH_FMT_AF, PH_FMT_CH, PH_FMT_SR,
                PH_FMT_BR, PH_FMT_BA, PH_FMT_BD: begin
                    if (idx_reg >= len_m1) begin
                        word_next = '0;
                        idx_next  = '0;
                        case (phase_reg)
                            PH_FORM: begin
                                phase_next = PH_ID;
                            end
                            PH_FMT_AF: begin
                                af_next    = word_ins[15:0];
                                phase_next = PH_FMT_CH;
                            end
                            PH_FMT_CH: begin
                                ch_next    = word_ins[15:0];
                                phase_next = PH_FMT_SR;
                            end
                            PH_FMT_SR: begin
                                sr_next    = word_ins;
                                phase_next = PH_FMT_BR;
                            end
                            PH_FMT_BR: begin
                                br_next    = word_ins;
                                phase_next = PH_FMT_BA;
                            end
                            PH_FMT_BA: begin
                                ba_next    = word_ins[15:0];
                                phase_next = PH_FMT_BD;
                            end
                            default: begin
                                bd_next    = word_ins[15:0];
                                phase_next = (skip_reg != '0) ? PH_SKIP : PH_ID;
                            end
                        endcase
                    end else begin
                        word_next = word_ins;
                        idx_next  = idx_reg + 3'd1;
                    end
                end
                PH_SKIP: begin
                    if (skip_reg != '0) begin
                        skip_next = skip_reg - 32'd1;
                    end
                    if (skip_reg <= 32'd1) begin
                        phase_next = PH_ID;
                    end
                end
                PH_DONE: begin
                    // bytes after a result are dropped
                end
                default: begin
                    phase_next = PH_ID;
                end
            endcase

            // format fields as they stand after this byte
            emit_af = af_next;
            emit_ch = ch_next;
            emit_sr = sr_next;
            emit_br = br_next;
            emit_ba = ba_next;
            emit_bd = bd_next;

            if (q_head.last_byte) begin
                if (!emit && phase_reg != PH_DONE) begin
                    emit      = 1'b1;
                    emit_st   = ST_CORRUPT;
                    emit_size = '0;
                    emit_off  = '0;
                end
                phase_next    = PH_ID;
                idx_next      = '0;
                word_next     = '0;
                chunk_id_next = '0;
                skip_next     = '0;
                af_next       = '0;
                ch_next       = '0;
                sr_next       = '0;
                br_next       = '0;
                ba_next       = '0;
                bd_next       = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_ID;
            idx_reg      <= '0;
            word_reg     <= '0;
            chunk_id_reg <= '0;
            skip_reg     <= '0;
            af_reg       <= '0;
            ch_reg       <= '0;
            sr_reg       <= '0;
            br_reg       <= '0;
            ba_reg       <= '0;
            bd_reg       <= '0;
            req_bd_reg   <= RST_BIT_DEPTH;
            req_ch_reg   <= RST_CHANNELS;
            m_valid_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            word_reg     <= word_next;
            chunk_id_reg <= chunk_id_next;
            skip_reg     <= skip_next;
            af_reg       <= af_next;
            ch_reg       <= ch_next;
            sr_reg       <= sr_next;
            br_reg       <= br_next;
            ba_reg       <= ba_next;
            bd_reg       <= bd_next;
            if (cfg_wr.wen) begin
                unique case (cfg_wr.index)
                    CFG_BIT_DEPTH: req_bd_reg <= cfg_wr.data;
                    CFG_CHANNELS:  req_ch_reg <= cfg_wr.data;
                    default: ;
                endcase
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            st_reg     <= emit_st;
            o_af_reg   <= emit_af;
            o_ch_reg   <= emit_ch;
            o_sr_reg   <= emit_sr;
            o_br_reg   <= emit_br;
            o_ba_reg   <= emit_ba;
            o_bd_reg   <= emit_bd;
            o_size_reg <= emit_size;
            o_off_reg  <= emit_off;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = st_reg;
    assign m_audio_format  = o_af_reg;
    assign m_channel_count = o_ch_reg;
    assign m_sample_rate   = o_sr_reg;
    assign m_byte_rate     = o_br_reg;
    assign m_block_align   = o_ba_reg;
    assign m_bit_depth     = o_bd_reg;
    assign m_data_size     = o_size_reg;
    assign m_data_offset   = o_off_reg;

endmodule : wcp_parser
`default_nettype wire
